### hw/rtl/framed_image_line_receiver_assert.svh
// assertion macros for the framed image line receiver checker
// used by fimr_chk; needs clk_i and rst_ni in scope
`ifndef FRAMED_IMAGE_LINE_RECEIVER_ASSERT_SVH
`define FRAMED_IMAGE_LINE_RECEIVER_ASSERT_SVH

// same-cycle implication
`define FIMR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FIMR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/fimr_pkg.sv
// shared types, constants and functions of the framed image line receiver
// no dependencies
`default_nettype none

package fimr_pkg;

  localparam int unsigned LineMaxDef     = 96;
  localparam int unsigned ImageWidthDef  = 152;
  localparam int unsigned ImageHeightDef = 296;
  localparam int unsigned FrameBytesDef  = 5624;

  localparam logic [31:0] CrcPoly = 32'hedb88320;

  localparam logic [3:0] CODE_PAYLOAD = 4'd0;
  localparam logic [3:0] CODE_OK      = 4'd1;
  localparam logic [3:0] CODE_CRC_ERR = 4'd2;
  localparam logic [3:0] CODE_PING    = 4'd3;
  localparam logic [3:0] CODE_STATUS  = 4'd4;
  localparam logic [3:0] CODE_GPIO    = 4'd5;
  localparam logic [3:0] CODE_I2CSCAN = 4'd6;
  localparam logic [3:0] CODE_BAD_HDR = 4'd7;
  localparam logic [3:0] CODE_UNSUPP  = 4'd8;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_TILDE = 8'h7e;

  localparam logic [63:0] STR_PING   = 64'("PING");
  localparam logic [63:0] STR_STATUS = 64'("STATUS");
  localparam logic [63:0] STR_DIAG   = 64'("DIAG");
  localparam logic [63:0] STR_GPIO   = 64'("GPIO ");
  localparam logic [63:0] STR_I2C    = 64'("I2CSCAN");
  localparam logic [63:0] STR_TAG    = {16'h0, 8'h51, 8'h30, 8'h49, 8'h4d, 8'h47, 8'h31};
  localparam logic [63:0] STR_FMT    = 64'("1BPP");

  typedef struct packed {
    logic push;
    logic clear;
    logic pay_start;
    logic pay_step;
  } fimr_cmd_t;

  typedef struct packed {
    logic       is_cr;
    logic       is_lf;
    logic       is_print;
    logic       len_zero;
    logic       len_full;
    logic [3:0] cls_code;
    logic       pay_last;
    logic       crc_ok;
  } fimr_sts_t;

  // character i of a right-aligned literal of n characters
  function automatic logic [7:0] str_ch(logic [63:0] s, logic [2:0] n, logic [2:0] i);
    logic [2:0] k;
    k = n - 3'd1 - i;
    return s[{k, 3'b000} +: 8];
  endfunction

  // one byte of reflected crc-32
  function automatic logic [31:0] crc_step(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/fimr_dp.sv
// datapath: line tracker and header parser, payload counter and crc
// depends on fimr_pkg
`default_nettype none

module fimr_dp #(
  parameter int unsigned LINE_MAX     = fimr_pkg::LineMaxDef,
  parameter int unsigned IMAGE_WIDTH  = fimr_pkg::ImageWidthDef,
  parameter int unsigned IMAGE_HEIGHT = fimr_pkg::ImageHeightDef,
  parameter int unsigned FRAME_BYTES  = fimr_pkg::FrameBytesDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [7:0]          byte_i,
  input  wire fimr_pkg::fimr_cmd_t cmd_i,
  output fimr_pkg::fimr_sts_t      sts_o
);
  import fimr_pkg::*;

  localparam int unsigned LW = $clog2(LINE_MAX);
  localparam int unsigned CW = $clog2(FRAME_BYTES + 1);

  localparam logic [3:0] IP_TAG  = 4'd0;
  localparam logic [3:0] IP_SP   = 4'd1;
  localparam logic [3:0] IP_SGN  = 4'd2;
  localparam logic [3:0] IP_DIG  = 4'd3;
  localparam logic [3:0] IP_ZERO = 4'd4;
  localparam logic [3:0] IP_PFX  = 4'd5;
  localparam logic [3:0] IP_TSP  = 4'd6;
  localparam logic [3:0] IP_TOK  = 4'd7;
  localparam logic [3:0] IP_DONE = 4'd8;
  localparam logic [3:0] IP_FAIL = 4'd9;

  localparam logic [1:0] F_W   = 2'd0;
  localparam logic [1:0] F_H   = 2'd1;
  localparam logic [1:0] F_LEN = 2'd2;
  localparam logic [1:0] F_CRC = 2'd3;

  localparam logic [2:0] IQ_PRE  = 3'd0;
  localparam logic [2:0] IQ_SP1  = 3'd1;
  localparam logic [2:0] IQ_SGN1 = 3'd2;
  localparam logic [2:0] IQ_DIG1 = 3'd3;
  localparam logic [2:0] IQ_SP2  = 3'd4;
  localparam logic [2:0] IQ_SGN2 = 3'd5;
  localparam logic [2:0] IQ_OK   = 3'd6;
  localparam logic [2:0] IQ_FAIL = 3'd7;

  logic [LW-1:0] len_q, len_d;
  logic ping_q, ping_d, stat_q, stat_d, diag_q, diag_d, gpio_q, gpio_d;
  logic [2:0]  iq_q, iq_d;
  logic [3:0]  ph_q, ph_d;
  logic [1:0]  fld_q, fld_d;
  logic [31:0] acc_q, acc_d;
  logic        neg_q, neg_d;
  logic [2:0]  tn_q, tn_d;
  logic        tok_q, tok_d;
  logic [31:0] hcrc_q, hcrc_d;
  logic [31:0] crc_q, crc_d, exp_q, exp_d;
  logic [CW-1:0] cnt_q, cnt_d;

  logic [7:0]  c;
  logic [2:0]  pi;
  logic        is_sp, is_sgn, is_dec, is_hex, is_d, hexf;
  logic [3:0]  dv;
  logic [35:0] dec_w;
  logic [31:0] hex_w, nv, tgt, img_crc;
  logic        ovf, img_ok;
  logic [31:0] crc_nx;
  logic [3:0]  cls;

  function automatic logic [3:0] num_start(logic sp, logic sgn, logic dig, logic zero_crc);
    if (sp) begin
      return IP_SP;
    end else if (sgn) begin
      return IP_SGN;
    end else if (zero_crc) begin
      return IP_ZERO;
    end else if (dig) begin
      return IP_DIG;
    end
    return IP_FAIL;
  endfunction

  assign c      = byte_i;
  assign pi     = len_q[2:0];
  assign is_sp  = (c == CH_SP);
  assign is_sgn = (c == CH_PLUS) || (c == CH_MINUS);
  assign is_dec = (c >= CH_ZERO) && (c <= 8'h39);
  assign is_hex = is_dec || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
  assign dv     = is_dec ? c[3:0] : 4'(c[3:0] + 4'd9);
  assign hexf   = (fld_q == F_CRC);
  assign is_d   = hexf ? is_hex : is_dec;
  assign dec_w  = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {32'h0, dv};
  assign hex_w  = {acc_q[27:0], dv};
  assign ovf    = hexf ? (acc_q[31:28] != 4'h0) : (dec_w[35:32] != 4'h0);
  assign nv     = neg_q ? (32'h0 - acc_q) : acc_q;

  always_comb begin
    case (fld_q)
      F_W:     tgt = 32'(IMAGE_WIDTH);
      F_H:     tgt = 32'(IMAGE_HEIGHT);
      default: tgt = 32'(FRAME_BYTES);
    endcase
  end

  // per-character header tracking
  always_comb begin
    len_d  = len_q;
    ping_d = ping_q;
    stat_d = stat_q;
    diag_d = diag_q;
    gpio_d = gpio_q;
    iq_d   = iq_q;
    ph_d   = ph_q;
    fld_d  = fld_q;
    acc_d  = acc_q;
    neg_d  = neg_q;
    tn_d   = tn_q;
    tok_d  = tok_q;
    hcrc_d = hcrc_q;
    if (cmd_i.clear) begin
      len_d  = '0;
      ping_d = 1'b1;
      stat_d = 1'b1;
      diag_d = 1'b1;
      gpio_d = 1'b1;
      iq_d   = IQ_PRE;
      ph_d   = IP_TAG;
    end else if (cmd_i.push) begin
      len_d  = len_q + LW'(1);
      ping_d = ping_q && (len_q < LW'(4)) && (c == str_ch(STR_PING, 3'd4, pi));
      stat_d = stat_q && (len_q < LW'(6)) && (c == str_ch(STR_STATUS, 3'd6, pi));
      diag_d = diag_q && (len_q < LW'(4)) && (c == str_ch(STR_DIAG, 3'd4, pi));
      gpio_d = gpio_q && ((len_q >= LW'(5)) || (c == str_ch(STR_GPIO, 3'd5, pi)));

      case (iq_q)
        IQ_PRE: begin
          if (c != str_ch(STR_I2C, 3'd7, pi)) begin
            iq_d = IQ_FAIL;
          end else if (pi == 3'd6) begin
            iq_d = IQ_SP1;
          end
        end
        IQ_SP1: begin
          iq_d = is_sp ? IQ_SP1 : is_sgn ? IQ_SGN1 : is_dec ? IQ_DIG1 : IQ_FAIL;
        end
        IQ_SGN1: iq_d = is_dec ? IQ_DIG1 : IQ_FAIL;
        IQ_DIG1: begin
          iq_d = is_dec ? IQ_DIG1 : is_sp ? IQ_SP2 : is_sgn ? IQ_SGN2 : IQ_FAIL;
        end
        IQ_SP2: begin
          iq_d = is_sp ? IQ_SP2 : is_sgn ? IQ_SGN2 : is_dec ? IQ_OK : IQ_FAIL;
        end
        IQ_SGN2: iq_d = is_dec ? IQ_OK : IQ_FAIL;
        IQ_OK:   iq_d = IQ_OK;
        default: iq_d = IQ_FAIL;
      endcase

      case (ph_q)
        IP_TAG: begin
          if (c != str_ch(STR_TAG, 3'd6, pi)) begin
            ph_d = IP_FAIL;
          end else if (pi == 3'd5) begin
            ph_d  = IP_SP;
            fld_d = F_W;
          end
        end
        IP_SP: begin
          if (!is_sp) begin
            ph_d  = num_start(1'b0, is_sgn, is_d, hexf && (c == CH_ZERO));
            acc_d = {28'h0, dv};
            neg_d = (c == CH_MINUS);
          end
        end
        IP_SGN: begin
          ph_d  = (hexf && (c == CH_ZERO)) ? IP_ZERO : is_d ? IP_DIG : IP_FAIL;
          acc_d = {28'h0, dv};
        end
        IP_ZERO: begin
          if ((c == CH_X_LO) || (c == CH_X_UP)) begin
            ph_d = IP_PFX;
          end else if (is_hex) begin
            ph_d  = IP_DIG;
            acc_d = {28'h0, dv};
          end else begin
            ph_d   = IP_DONE;
            hcrc_d = 32'h0;
          end
        end
        IP_PFX: begin
          ph_d  = is_hex ? IP_DIG : IP_FAIL;
          acc_d = {28'h0, dv};
        end
        IP_DIG: begin
          if (is_d) begin
            ph_d  = ovf ? IP_FAIL : IP_DIG;
            acc_d = hexf ? hex_w : dec_w[31:0];
          end else if (hexf) begin
            ph_d   = IP_DONE;
            hcrc_d = nv;
          end else if (nv != tgt) begin
            ph_d = IP_FAIL;
          end else if (fld_q == F_H) begin
            ph_d  = is_sp ? IP_TSP : IP_TOK;
            tn_d  = 3'd1;
            tok_d = (c == CH_ONE);
          end else begin
            fld_d = (fld_q == F_W) ? F_H : F_CRC;
            ph_d  = num_start(is_sp, is_sgn, (fld_q == F_LEN) && is_hex,
                              (fld_q == F_LEN) && (c == CH_ZERO));
            acc_d = {28'h0, dv};
            neg_d = (c == CH_MINUS);
          end
        end
        IP_TSP: begin
          if (!is_sp) begin
            ph_d  = IP_TOK;
            tn_d  = 3'd1;
            tok_d = (c == CH_ONE);
          end
        end
        IP_TOK: begin
          if (is_sp) begin
            ph_d  = ((tn_q == 3'd4) && tok_q) ? IP_SP : IP_FAIL;
            fld_d = F_LEN;
          end else if (tn_q == 3'd4) begin
            ph_d = IP_FAIL;
          end else begin
            tn_d  = tn_q + 3'd1;
            tok_d = tok_q && (c == str_ch(STR_FMT, 3'd4, tn_q));
          end
        end
        IP_DONE: ph_d = IP_DONE;
        default: ph_d = IP_FAIL;
      endcase
    end
  end

  // line verdict at line end
  always_comb begin
    img_ok  = (ph_q == IP_DONE) || (ph_q == IP_ZERO) ||
              ((ph_q == IP_DIG) && (fld_q == F_CRC));
    img_crc = (ph_q == IP_DONE) ? hcrc_q : (ph_q == IP_ZERO) ? 32'h0 : nv;
    if (ping_q && (len_q == LW'(4))) begin
      cls = CODE_PING;
    end else if ((stat_q && (len_q == LW'(6))) || (diag_q && (len_q == LW'(4)))) begin
      cls = CODE_STATUS;
    end else if (gpio_q && (len_q >= LW'(5))) begin
      cls = CODE_GPIO;
    end else if (iq_q == IQ_OK) begin
      cls = CODE_I2CSCAN;
    end else if (img_ok) begin
      cls = CODE_PAYLOAD;
    end else begin
      cls = CODE_UNSUPP;
    end
  end

  assign crc_nx = crc_step(crc_q, byte_i);

  always_comb begin
    crc_d = crc_q;
    exp_d = exp_q;
    cnt_d = cnt_q;
    if (cmd_i.pay_start) begin
      crc_d = '1;
      exp_d = img_crc;
      cnt_d = '0;
    end else if (cmd_i.pay_step) begin
      crc_d = crc_nx;
      cnt_d = (cnt_q == CW'(FRAME_BYTES - 1)) ? '0 : cnt_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      ping_q <= 1'b1;
      stat_q <= 1'b1;
      diag_q <= 1'b1;
      gpio_q <= 1'b1;
      iq_q   <= IQ_PRE;
      ph_q   <= IP_TAG;
      crc_q  <= '1;
      exp_q  <= '0;
      cnt_q  <= '0;
    end else begin
      len_q  <= len_d;
      ping_q <= ping_d;
      stat_q <= stat_d;
      diag_q <= diag_d;
      gpio_q <= gpio_d;
      iq_q   <= iq_d;
      ph_q   <= ph_d;
      crc_q  <= crc_d;
      exp_q  <= exp_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fld_q  <= fld_d;
    acc_q  <= acc_d;
    neg_q  <= neg_d;
    tn_q   <= tn_d;
    tok_q  <= tok_d;
    hcrc_q <= hcrc_d;
  end

  assign sts_o.is_cr    = (c == CH_CR);
  assign sts_o.is_lf    = (c == CH_LF);
  assign sts_o.is_print = (c >= CH_SP) && (c <= CH_TILDE);
  assign sts_o.len_zero = (len_q == '0);
  assign sts_o.len_full = (len_q == LW'(LINE_MAX - 2));
  assign sts_o.cls_code = cls;
  assign sts_o.pay_last = (cnt_q == CW'(FRAME_BYTES - 1));
  assign sts_o.crc_ok   = (~crc_nx == exp_q);

endmodule

`default_nettype wire

### hw/rtl/fimr_ctrl.sv
// controller: line/payload mode machine, commands and output register
// depends on fimr_pkg
`default_nettype none

module fimr_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [7:0]          byte_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [15:0]              out_data_o,
  output fimr_pkg::fimr_cmd_t      cmd_o,
  input  wire fimr_pkg::fimr_sts_t sts_i
);
  import fimr_pkg::*;

  localparam logic ST_LINE = 1'b0;
  localparam logic ST_PAY  = 1'b1;

  logic        state_q, state_d;
  logic        ov_q, ov_d;
  logic [15:0] od_q, od_d;
  logic        acc, emit;
  logic [3:0]  code;
  logic [7:0]  pb;

  assign in_ready_o = !ov_q || out_ready_i;
  assign acc        = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o   = '0;
    emit    = 1'b0;
    code    = CODE_PAYLOAD;
    pb      = 8'h0;
    state_d = state_q;
    case (state_q)
      ST_PAY: begin
        if (acc) begin
          cmd_o.pay_step = 1'b1;
          emit           = 1'b1;
          pb             = byte_i;
          if (sts_i.pay_last) begin
            code    = sts_i.crc_ok ? CODE_OK : CODE_CRC_ERR;
            state_d = ST_LINE;
          end
        end
      end
      default: begin
        if (acc && !sts_i.is_cr) begin
          if (sts_i.is_lf) begin
            cmd_o.clear = 1'b1;
            if (sts_i.len_zero) begin
              emit = 1'b1;
              code = CODE_BAD_HDR;
            end else if (sts_i.cls_code == CODE_PAYLOAD) begin
              cmd_o.pay_start = 1'b1;
              state_d         = ST_PAY;
            end else begin
              emit = 1'b1;
              code = sts_i.cls_code;
            end
          end else if (sts_i.is_print) begin
            if (sts_i.len_full) begin
              cmd_o.clear = 1'b1;
              emit        = 1'b1;
              code        = CODE_BAD_HDR;
            end else begin
              cmd_o.push = 1'b1;
            end
          end else begin
            cmd_o.clear = 1'b1;
          end
        end
      end
    endcase
  end

  always_comb begin
    ov_d = ov_q;
    od_d = od_q;
    if (emit) begin
      ov_d = 1'b1;
      od_d = {4'h0, pb, code};
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LINE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    od_q <= od_d;
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

endmodule

`default_nettype wire

### hw/rtl/framed_image_line_receiver.sv
// Framed image line receiver, top level. Takes one byte per cycle whenever the
// one-entry output register is empty or being drained in the same cycle, so the
// sustained rate is one byte per clock; the input stalls only while a result
// sits in the output register and the downstream side holds tready low. Header
// lines are parsed character by character as they arrive, so the line end is
// classified in the cycle it is taken. A valid image header switches to payload
// mode for FRAME_BYTES bytes, each forwarded; the last carries the crc verdict.
// Depends on fimr_pkg, fimr_ctrl and fimr_dp.
`default_nettype none

module framed_image_line_receiver #(
  parameter int unsigned LINE_MAX     = fimr_pkg::LineMaxDef,
  parameter int unsigned IMAGE_WIDTH  = fimr_pkg::ImageWidthDef,
  parameter int unsigned IMAGE_HEIGHT = fimr_pkg::ImageHeightDef,
  parameter int unsigned FRAME_BYTES  = fimr_pkg::FrameBytesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata    // [3:0] result_code, [11:4] payload_byte, rest 0
);
  import fimr_pkg::*;

  fimr_cmd_t cmd;
  fimr_sts_t sts;

  fimr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .byte_i      (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  fimr_dp #(
    .LINE_MAX     (LINE_MAX),
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT),
    .FRAME_BYTES  (FRAME_BYTES)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (s_axis_tdata),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

endmodule

`default_nettype wire

### hw/rtl/fimr_chk.sv
// port-level checker for framed_image_line_receiver, bound to the top level
// depends on framed_image_line_receiver_assert.svh
`default_nettype none

`include "framed_image_line_receiver_assert.svh"

module fimr_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [7:0]  s_axis_tdata,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata
);

  `FIMR_ASSERT_NOW(a_stall_only_on_full_out, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled without a waiting result")
  `FIMR_ASSERT_NOW(a_pad_and_code, m_axis_tvalid, (m_axis_tdata[15:12] == 4'h0) && (m_axis_tdata[3:0] <= 4'd8), "bad padding or result code")
  `FIMR_ASSERT_NOW(a_line_codes_no_byte, m_axis_tvalid && (m_axis_tdata[3:0] >= 4'd3), m_axis_tdata[11:4] == 8'h0, "line result with a payload byte")
  `FIMR_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

  logic unused_in;
  assign unused_in = s_axis_tvalid ^ (^s_axis_tdata);

endmodule

bind framed_image_line_receiver fimr_chk u_chk (.*);

`default_nettype wire

### verif/tb_framed_image_line_receiver.sv
// self-checking testbench for framed_image_line_receiver: directed lines, random
// header traffic and a payload run, checked against a byte-level predictor
// depends on fimr_pkg and the framed_image_line_receiver rtl
`default_nettype none

module tb_framed_image_line_receiver;
  timeunit 1ns;
  timeprecision 1ps;

  import fimr_pkg::*;

  localparam int unsigned LineMax   = LineMaxDef;
  localparam int unsigned FrameLen  = FrameBytesDef;
  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned RandBytes = 850;
  localparam int unsigned PayBytes  = 120;
  localparam logic [3:0]  NO_CODE   = 4'hf;

  typedef struct packed {
    logic [3:0] code;
    logic [7:0] data;
  } rx_result_t;

  typedef struct {
    string      text;
    logic [3:0] code;
  } line_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [15:0] m_axis_tdata;

  rx_result_t  result_q[$];
  int unsigned err_cnt, idle_cycles, bytes_sent, results_seen, rdy_idle;
  bit          idle_on = 1'b1;

  logic [6:0]  line_buf [0:LineMax-1];
  int unsigned line_len;
  bit          pay_mode;
  int unsigned pay_cnt;
  logic [31:0] crc_run, crc_want;

  framed_image_line_receiver i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  function automatic bit ch_at(int unsigned p, logic [7:0] c);
    return p < line_len && p < LineMax && {1'b0, line_buf[p]} == c;
  endfunction

  function automatic bit match_lit(string s, inout int unsigned p);
    for (int i = 0; i < s.len(); i++) begin
      if (!ch_at(p + i, s[i])) return 1'b0;
    end
    p += s.len();
    return 1'b1;
  endfunction

  function automatic int digit_of(logic [7:0] c, int unsigned base);
    if (c >= "0" && c <= "9") return c - "0";
    if (base == 16 && c >= "a" && c <= "f") return c - "a" + 10;
    if (base == 16 && c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  function automatic bit scan_num(inout int unsigned p, input int unsigned base,
                                  output logic [31:0] v, output bit ovf);
    logic [31:0] acc;
    int unsigned cnt;
    bit neg;
    int d;
    acc = '0;
    cnt = 0;
    neg = 1'b0;
    ovf = 1'b0;
    v = '0;
    while (ch_at(p, CH_SP)) p++;
    if (ch_at(p, CH_PLUS) || ch_at(p, CH_MINUS)) begin
      neg = ch_at(p, CH_MINUS);
      p++;
    end
    if (base == 16 && ch_at(p, CH_ZERO) && (ch_at(p + 1, CH_X_LO) || ch_at(p + 1, CH_X_UP)))
      p += 2;
    while (p < line_len && p < LineMax) begin
      d = digit_of({1'b0, line_buf[p]}, base);
      if (d < 0) break;
      if (acc > (32'hffffffff - 32'(d)) / base) ovf = 1'b1;
      acc = acc * base + 32'(d);
      cnt++;
      p++;
    end
    if (cnt == 0) return 1'b0;
    v = neg ? -acc : acc;
    return 1'b1;
  endfunction

  function automatic bit scan_fmt(inout int unsigned p);
    string tok;
    tok = "";
    while (ch_at(p, CH_SP)) p++;
    while (tok.len() < 7 && p < line_len && p < LineMax && {1'b0, line_buf[p]} != CH_SP) begin
      tok = {tok, string'({1'b0, line_buf[p]})};
      p++;
    end
    return tok == "1BPP";
  endfunction

  function automatic string img_tag();
    return string'(48'h5130494d4731);
  endfunction

  function automatic logic [3:0] classify_line();
    int unsigned p;
    logic [31:0] a, b, w, h, n, c;
    bit o1, o2, o3, o4;
    p = 0;
    if (line_len == 4 && match_lit("PING", p)) return CODE_PING;
    p = 0;
    if (line_len == 6 && match_lit("STATUS", p)) return CODE_STATUS;
    p = 0;
    if (line_len == 4 && match_lit("DIAG", p)) return CODE_STATUS;
    p = 0;
    if (match_lit("GPIO ", p)) return CODE_GPIO;
    p = 0;
    if (match_lit("I2CSCAN", p) && scan_num(p, 10, a, o1) && scan_num(p, 10, b, o1))
      return CODE_I2CSCAN;
    p = 0;
    if (!match_lit(img_tag(), p)) return CODE_UNSUPP;
    if (!scan_num(p, 10, w, o1) || !scan_num(p, 10, h, o2)) return CODE_UNSUPP;
    if (!scan_fmt(p)) return CODE_UNSUPP;
    if (!scan_num(p, 10, n, o3) || !scan_num(p, 16, c, o4)) return CODE_UNSUPP;
    if (o1 || o2 || o3 || o4) return CODE_UNSUPP;
    if (w != ImageWidthDef || h != ImageHeightDef || n != FrameLen) return CODE_UNSUPP;
    crc_want = c;
    return CODE_PAYLOAD;
  endfunction

  // returns NO_CODE when the byte causes no transaction on the output
  function automatic rx_result_t predict_byte(logic [7:0] b);
    rx_result_t r;
    r = '{code: NO_CODE, data: 8'h00};
    if (pay_mode) begin
      crc_run = crc_step_tb(crc_run, b);
      pay_cnt++;
      r = '{code: CODE_PAYLOAD, data: b};
      if (pay_cnt >= FrameLen) begin
        r.code = (~crc_run == crc_want) ? CODE_OK : CODE_CRC_ERR;
        pay_mode = 1'b0;
        pay_cnt = 0;
        line_len = 0;
      end
    end else if (b == CH_CR) begin
    end else if (b == CH_LF) begin
      if (line_len == 0) begin
        r.code = CODE_BAD_HDR;
      end else begin
        r.code = classify_line();
        line_len = 0;
        if (r.code == CODE_PAYLOAD) begin
          r.code = NO_CODE;
          pay_mode = 1'b1;
          pay_cnt = 0;
          crc_run = '1;
        end
      end
    end else if (b >= CH_SP && b <= CH_TILDE) begin
      if (line_len < LineMax) line_buf[line_len] = b[6:0];
      line_len++;
      if (line_len >= LineMax - 1) begin
        line_len = 0;
        r.code = CODE_BAD_HDR;
      end
    end else begin
      line_len = 0;
    end
    return r;
  endfunction

  function automatic logic [31:0] crc_step_tb(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int i = 0; i < 8; i++) c = {1'b0, c[31:1]} ^ (32'hedb88320 & {32{c[0]}});
    return c;
  endfunction

  task automatic send_byte(logic [7:0] b, logic [3:0] fixed_code);
    rx_result_t r;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
    r = predict_byte(b);
    if (r.code != NO_CODE) begin
      if (fixed_code != NO_CODE) r.code = fixed_code;
      result_q.push_back(r);
    end
  endtask

  task automatic send_line(string s, logic [3:0] fixed_code);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], (i == s.len() - 1) ? fixed_code : NO_CODE);
  endtask

  function automatic string hdr_line(logic [31:0] crc, int unsigned variant);
    int unsigned w, h, n;
    string fmt, crc_txt;
    w = ImageWidthDef;
    h = ImageHeightDef;
    n = FrameLen;
    fmt = "1BPP";
    crc_txt = $sformatf("0x%08x", crc);
    case (variant)
      1: w = w + 1;
      2: h = h - 1;
      3: n = n + $urandom_range(1, 3);
      4: fmt = "1BPPX";
      5: crc_txt = "0x";
      6: crc_txt = "123456789ab";
      7: return $sformatf("%s %0d99999999999 %0d 1BPP %0d 0", img_tag(), w, h, n);
      8: return $sformatf("%s%0d+%0d 1BPP %0d %08X", img_tag(), w, h, n, crc);
      default: ;
    endcase
    return $sformatf("%s %0d  %0d %s %0d %s", img_tag(), w, h, fmt, n, crc_txt);
  endfunction

  task automatic send_frame(bit upper, int unsigned n_bytes);
    logic [7:0] pay;
    logic [31:0] crc;
    crc = $urandom;
    send_line({upper ? hdr_line(crc, 8) : hdr_line(crc, 0), "\r\n"}, NO_CODE);
    for (int unsigned i = 0; i < n_bytes; i++) begin
      pay = (i < 4) ? ((i % 2) ? CH_LF : CH_CR) : 8'($urandom);
      send_byte(pay, NO_CODE);
    end
  endtask

  function automatic string rand_line();
    string s;
    s = "";
    case ($urandom_range(0, 11))
      0: s = "PING";
      1: s = ($urandom_range(0, 1)) ? "STATUS" : "DIAG";
      2: s = $sformatf("GPIO %0d %0d", $urandom_range(0, 40), $urandom_range(0, 1));
      3: s = $sformatf("I2CSCAN %0d %0d", $signed($urandom), $urandom_range(0, 99));
      4: s = $sformatf("I2CSCAN%0d", $urandom_range(0, 9));
      5, 6: s = hdr_line($urandom, $urandom_range(1, 7));
      7: repeat ($urandom_range(1, 20)) s = {s, string'(8'($urandom_range(32, 126)))};
      8: repeat ($urandom_range(90, 100)) s = {s, string'(8'($urandom_range(32, 126)))};
      9: repeat ($urandom_range(1, 6)) s = {s, string'(8'($urandom_range(1, 255)))};
      10: s = "PINGPING";
      default: s = "";
    endcase
    if ($urandom_range(0, 5) == 0) s = {s, "\r"};
    return {s, "\n"};
  endfunction

  always @(posedge clk_i) begin
    if (rdy_idle != 0) begin
      rdy_idle <= rdy_idle - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      m_axis_tready <= 1'b0;
      rdy_idle      <= $urandom_range(0, 9);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    rx_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (result_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected transaction: code %0d byte %02x",
                                    m_axis_tdata[3:0], m_axis_tdata[11:4]);
      end else begin
        want = result_q.pop_front();
        if (m_axis_tdata[3:0] != want.code || m_axis_tdata[11:4] != want.data ||
            m_axis_tdata[15:12] != 4'h0) begin
          err_cnt++;
          if (err_cnt <= 10) $display("mismatch: expected code %0d byte %02x, got %04x",
                                      want.code, want.data, m_axis_tdata);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no transaction for %0d cycles", IdleLimit);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    line_row_t rows [$];
    string long_line;
    long_line = "";
    repeat (LineMax - 1) long_line = {long_line, "~"};
    rows = '{
      '{"\n", CODE_BAD_HDR}, '{"PING\n", CODE_PING}, '{"STATUS\n", CODE_STATUS},
      '{"DIAG\n", CODE_STATUS}, '{"GPIO 5 1\n", CODE_GPIO}, '{"I2CSCAN 1 -2\n", CODE_I2CSCAN},
      '{"I2CSCAN 99999999999 +3\n", CODE_I2CSCAN}, '{"I2CSCAN 7\n", CODE_UNSUPP},
      '{"HELLO\n", CODE_UNSUPP}, '{"PING\r\n", CODE_PING}, '{"PINGX\n", CODE_UNSUPP},
      '{"ping\n", CODE_UNSUPP}, '{" PING\n", CODE_UNSUPP}, '{long_line, CODE_BAD_HDR},
      '{"PI\001PING\n", CODE_PING}, '{"ST\377PING\n", CODE_PING}, '{"\r\r\n", CODE_BAD_HDR},
      '{{" !", long_line.substr(0, 90), "\n"}, NO_CODE},
      '{{hdr_line(32'h0, 1), "\n"}, CODE_UNSUPP}, '{{hdr_line(32'h0, 4), "\n"}, CODE_UNSUPP},
      '{{hdr_line(32'h0, 5), "\n"}, CODE_UNSUPP}, '{{hdr_line(32'h0, 7), "\n"}, CODE_UNSUPP},
      '{{img_tag(), " 152 296 1BPP -5624 0\n"}, CODE_UNSUPP}
    };
    line_len = 0;
    pay_mode = 1'b0;
    pay_cnt = 0;
    crc_run = '1;
    crc_want = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) send_line(rows[i].text, rows[i].code);
    while (bytes_sent < RandBytes - PayBytes - 40) send_line(rand_line(), NO_CODE);
    idle_on = 1'b0;
    send_frame(1'b1, PayBytes);
    s_axis_tvalid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("sent %0d bytes: directed and random header lines, then %0d payload bytes",
             bytes_sent, PayBytes);
    $display("checked %0d result transactions", results_seen);
    if (err_cnt == 0 && result_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
